FILE: rtl/dgcc_pkg.sv
package dgcc_pkg;

    localparam int NUM_VERTICES_DEFAULT = 16;

    // fixed field widths of the stream items
    localparam int ROW_INDEX_W   = 4;
    localparam int ROW_BITS_W    = 16;
    localparam int IN_DATA_W     = 24;
    localparam int CYCLE_COUNT_W = 40;
    localparam int COUNT_W       = 41;

    // configuration
    localparam int                 LEN_W      = 5;
    localparam logic [LEN_W-1:0]   LEN_RESET  = 5'd3;
    localparam logic [LEN_W-1:0]   LEN_MIN    = 5'd3;
    localparam int                 APB_DATA_W = 32;
    localparam int                 APB_ADDR_W = 3;

    // register index, taken from paddr[2]
    localparam logic REG_CYCLE_LENGTH = 1'b0;

    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] cycle_length;
        logic             result_ack;
    } dgcc_walk_ctrl_t;

    typedef struct packed {
        logic               idle;
        logic               result_valid;
        logic [COUNT_W-1:0] count;
    } dgcc_walk_stat_t;

endpackage

FILE: rtl/dgcc_ram.sv
module dgcc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/dgcc_adj_store.sv
module dgcc_adj_store
    import dgcc_pkg::*;
#(
    parameter int NUM_VERTICES = NUM_VERTICES_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            we,
    input  logic [$clog2(NUM_VERTICES)-1:0] waddr,
    input  logic [NUM_VERTICES-1:0]         wdata,
    input  logic [$clog2(NUM_VERTICES)-1:0] raddr,
    output logic [NUM_VERTICES-1:0]         rdata
);

    logic [NUM_VERTICES-1:0] row_valid_reg;
    logic                    rd_valid_reg;
    logic [NUM_VERTICES-1:0] ram_q;

    dgcc_ram #(
        .WIDTH (NUM_VERTICES),
        .DEPTH (NUM_VERTICES)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ram_q)
    );

    // rows never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                row_valid_reg[waddr] <= 1'b1;
            end
            rd_valid_reg <= row_valid_reg[raddr];
        end
    end

    assign rdata = ram_q & {NUM_VERTICES{rd_valid_reg}};

endmodule

FILE: rtl/dgcc_walker.sv
module dgcc_walker
    import dgcc_pkg::*;
#(
    parameter int NUM_VERTICES = NUM_VERTICES_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  dgcc_walk_ctrl_t                 ctrl,
    output dgcc_walk_stat_t                 stat,
    output logic [$clog2(NUM_VERTICES)-1:0] adj_raddr,
    input  logic [NUM_VERTICES-1:0]         adj_rdata
);

    localparam int VW   = $clog2(NUM_VERTICES);
    localparam int NW   = $clog2(NUM_VERTICES + 1);
    localparam int SW   = VW + NW;
    localparam int SUMW = $clog2(NUM_VERTICES + (2 ** LEN_W));

    typedef enum logic [2:0] {
        W_IDLE,
        W_START,
        W_NEXT_START,
        W_ROW_WAIT,
        W_SCAN,
        W_CLOSE,
        W_POP_WAIT,
        W_DONE
    } walk_state_t;

    walk_state_t             state_reg;
    logic [LEN_W-1:0]        len_reg;
    logic [VW-1:0]           s_reg;
    logic [VW-1:0]           depth_reg;
    logic [VW-1:0]           cur_v_reg;
    logic [NW-1:0]           cur_i_reg;
    logic [NUM_VERTICES-1:0] visited_reg;
    logic [NUM_VERTICES-1:0] row_reg;
    logic [COUNT_W-1:0]      count_reg;

    logic [NUM_VERTICES-1:0] ge_mask;
    logic [NUM_VERTICES-1:0] start_mask;
    logic [NUM_VERTICES-1:0] avail;
    logic                    found;
    logic [VW-1:0]           found_idx;
    logic                    at_last_edge;
    logic                    start_out_of_range;
    logic                    len_too_long;

    logic          stk_we;
    logic [VW-1:0] stk_waddr;
    logic [SW-1:0] stk_wdata;
    logic [VW-1:0] stk_raddr;
    logic [SW-1:0] stk_rdata;
    logic [VW-1:0] pop_v;
    logic [NW-1:0] pop_i;

    dgcc_ram #(
        .WIDTH (SW),
        .DEPTH (NUM_VERTICES)
    ) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign pop_v = stk_rdata[SW-1:NW];
    assign pop_i = stk_rdata[NW-1:0];

    // candidate search from the resume index upward
    always_comb
    begin
        for (int k = 0; k < NUM_VERTICES; k++)
        begin
            ge_mask[k]    = (NW'(k) >= cur_i_reg);
            start_mask[k] = (VW'(k) <= s_reg);
        end
        avail     = row_reg & ~visited_reg & ge_mask;
        found     = 1'b0;
        found_idx = '0;
        for (int k = NUM_VERTICES - 1; k >= 0; k--)
        begin
            if (avail[k])
            begin
                found     = 1'b1;
                found_idx = VW'(k);
            end
        end
    end

    assign at_last_edge       = (SUMW'(depth_reg) + SUMW'(2)) == SUMW'(len_reg);
    assign start_out_of_range = (SUMW'(s_reg) + SUMW'(len_reg) - SUMW'(1))
                                >= SUMW'(NUM_VERTICES);
    assign len_too_long       = SUMW'(len_reg) > SUMW'(NUM_VERTICES);

    // memory ports
    always_comb
    begin
        adj_raddr = s_reg;
        stk_we    = 1'b0;
        stk_waddr = depth_reg;
        stk_wdata = {cur_v_reg, NW'(found_idx) + NW'(1)};
        stk_raddr = depth_reg - VW'(1);
        case (state_reg)
            W_SCAN:
            begin
                adj_raddr = found_idx;
                stk_we    = found && !at_last_edge;
            end
            W_POP_WAIT:
            begin
                adj_raddr = pop_v;
            end
            default:
            begin
                adj_raddr = s_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= W_IDLE;
            len_reg     <= LEN_RESET;
            s_reg       <= '0;
            depth_reg   <= '0;
            visited_reg <= '0;
            count_reg   <= '0;
            cur_v_reg   <= '0;
            cur_i_reg   <= '0;
            row_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                W_IDLE:
                begin
                    if (ctrl.start)
                    begin
                        len_reg   <= (ctrl.cycle_length < LEN_MIN) ? LEN_MIN
                                                                   : ctrl.cycle_length;
                        count_reg <= '0;
                        s_reg     <= '0;
                        depth_reg <= '0;
                        state_reg <= W_START;
                    end
                end
                W_START:
                begin
                    state_reg <= len_too_long ? W_DONE : W_NEXT_START;
                end
                W_NEXT_START:
                begin
                    if (start_out_of_range)
                    begin
                        state_reg <= W_DONE;
                    end
                    else
                    begin
                        visited_reg <= start_mask;
                        depth_reg   <= '0;
                        cur_v_reg   <= s_reg;
                        cur_i_reg   <= '0;
                        state_reg   <= W_ROW_WAIT;
                    end
                end
                W_ROW_WAIT:
                begin
                    row_reg   <= adj_rdata;
                    state_reg <= W_SCAN;
                end
                W_SCAN:
                begin
                    if (found)
                    begin
                        if (at_last_edge)
                        begin
                            cur_i_reg <= NW'(found_idx) + NW'(1);
                            state_reg <= W_CLOSE;
                        end
                        else
                        begin
                            depth_reg   <= depth_reg + VW'(1);
                            visited_reg <= visited_reg | (NUM_VERTICES'(1) << found_idx);
                            cur_v_reg   <= found_idx;
                            cur_i_reg   <= '0;
                            state_reg   <= W_ROW_WAIT;
                        end
                    end
                    else if (depth_reg == '0)
                    begin
                        s_reg     <= s_reg + VW'(1);
                        state_reg <= W_NEXT_START;
                    end
                    else
                    begin
                        visited_reg <= visited_reg & ~(NUM_VERTICES'(1) << cur_v_reg);
                        depth_reg   <= depth_reg - VW'(1);
                        state_reg   <= W_POP_WAIT;
                    end
                end
                W_CLOSE:
                begin
                    // closing edge back to the start vertex
                    if (adj_rdata[s_reg] && (count_reg != {COUNT_W{1'b1}}))
                    begin
                        count_reg <= count_reg + COUNT_W'(1);
                    end
                    state_reg <= W_SCAN;
                end
                W_POP_WAIT:
                begin
                    cur_v_reg <= pop_v;
                    cur_i_reg <= pop_i;
                    state_reg <= W_ROW_WAIT;
                end
                W_DONE:
                begin
                    if (ctrl.result_ack)
                    begin
                        state_reg <= W_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= W_IDLE;
                end
            endcase
        end
    end

    assign stat.idle         = (state_reg == W_IDLE);
    assign stat.result_valid = (state_reg == W_DONE);
    assign stat.count        = count_reg;

endmodule

FILE: rtl/dense_graph_cycle_counter.sv
// channel  | direction | signals                        | item
// ---------+-----------+--------------------------------+------------------------------
// s_axis   | in        | tvalid tready tdata tuser      | one adjacency row
// m_axis   | out       | tvalid tready tdata            | one cycle count
// apb      | in        | psel penable pwrite paddr ...  | cycle_length register
//
// rows load one per cycle while the walker is idle; a row flagged in tuser
// starts the count and s_axis_tready stays low until the count is handed to the output register
// count time is data dependent: it grows with each start vertex tried, each
// descent or closing-edge test and each backtrack (one adjacency or stack read each),
// plus a setup state, an end-of-starts check and a hand-off state
// the adjacency row store reads as zero from reset through per-row valid flags
// the count result sits in an output register; rows may load while it waits
module dense_graph_cycle_counter
    import dgcc_pkg::*;
#(
    parameter int NUM_VERTICES = NUM_VERTICES_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // [3:0] row_index, [19:4] row_bits, [23:20] zero
    input  logic [IN_DATA_W-1:0]     s_axis_tdata,
    // [0] last_row
    input  logic [0:0]               s_axis_tuser,

    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // [39:0] cycle_count
    output logic [CYCLE_COUNT_W-1:0] m_axis_tdata,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0]    pwdata,
    output logic [APB_DATA_W-1:0]    prdata,
    output logic                     pready
);

    localparam int VW = $clog2(NUM_VERTICES);

    logic [LEN_W-1:0]         cycle_length_reg;
    logic                     m_valid_reg;
    logic [CYCLE_COUNT_W-1:0] m_data_reg;

    logic                     in_accept;
    logic                     cfg_write;
    logic [ROW_INDEX_W-1:0]   row_index;
    logic [ROW_BITS_W-1:0]    row_bits;
    logic                     row_in_range;
    logic [NUM_VERTICES-1:0]  wr_row;
    logic                     result_take;

    logic [VW-1:0]            adj_raddr;
    logic [NUM_VERTICES-1:0]  adj_rdata;

    dgcc_walk_ctrl_t          walk_ctrl;
    dgcc_walk_stat_t          walk_stat;

    // input unpacking
    assign row_index    = s_axis_tdata[ROW_INDEX_W-1:0];
    assign row_bits     = s_axis_tdata[ROW_INDEX_W +: ROW_BITS_W];
    assign row_in_range = int'(row_index) < NUM_VERTICES;

    // row bits at or above the vertex count are dropped
    for (genvar k = 0; k < NUM_VERTICES; k++)
    begin : g_row
        if (k < ROW_BITS_W)
        begin : g_bit
            assign wr_row[k] = row_bits[k];
        end
        else
        begin : g_zero
            assign wr_row[k] = 1'b0;
        end
    end

    assign s_axis_tready = walk_stat.idle;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    dgcc_adj_store #(
        .NUM_VERTICES (NUM_VERTICES)
    ) u_adj (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (in_accept && row_in_range),
        .waddr (VW'(row_index)),
        .wdata (wr_row),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    // result moves to the output register once it is free
    assign result_take = walk_stat.result_valid && (!m_valid_reg || m_axis_tready);

    assign walk_ctrl.start        = in_accept && s_axis_tuser[0];
    assign walk_ctrl.cycle_length = cycle_length_reg;
    assign walk_ctrl.result_ack   = result_take;

    dgcc_walker #(
        .NUM_VERTICES (NUM_VERTICES)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (walk_ctrl),
        .stat      (walk_stat),
        .adj_raddr (adj_raddr),
        .adj_rdata (adj_rdata)
    );

    // configuration port, always ready
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_CYCLE_LENGTH)
        begin
            prdata = APB_DATA_W'(cycle_length_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_length_reg <= LEN_RESET;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write && (paddr[2] == REG_CYCLE_LENGTH))
            begin
                cycle_length_reg <= pwdata[LEN_W-1:0];
            end
            if (result_take)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // raw count holds each cycle twice, one per direction
    always_ff @(posedge clk)
    begin
        if (result_take)
        begin
            m_data_reg <= walk_stat.count[COUNT_W-1:1];
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule
